>>> rtl/wft_pkg.sv
// Shared types, status codes and default sizes for the word frequency table.
`timescale 1ns / 1ps

package wft_pkg;

   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_WORD_CHARS  = 32;

   localparam logic [2:0] ST_MATCH   = 3'd0;
   localparam logic [2:0] ST_INSERT  = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_READOUT = 3'd4;

   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  ch;
      logic        word_end;
      logic [31:0] add_count;
      logic [5:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [5:0]  entry_index;
      logic [7:0]  out_char;
      logic [31:0] word_count;
      logic [2:0]  status;
      logic        truncated;
      logic        last;
   } rsp_type;

endpackage

>>> rtl/word_frequency_table_unit.sv
// Word frequency table: word assembly, sequential table search, insert and readout.
//
//   channel | direction | payload          | handshake
//   req     | in        | wft_pkg::req_type | req_valid / req_ready
//   rsp     | out       | wft_pkg::rsp_type | rsp_valid / rsp_ready
//
// At word end a sequencer walks the entries in use: it checks each entry's stored
// length, compares the characters of an entry whose length matches, one by one,
// then updates the count of a match, inserts a new entry or reports a full table.
// A readout reads length and count, then sends each character, held until rsp_ready.
// Cost is set by the single read port of each table memory. Reset is synchronous
// and empties the table at once (entry count cleared, no clearing pass).
// req_ready is low while a search, insert or readout runs or a result waits.
`timescale 1ns / 1ps

module word_frequency_table_unit #(
   parameter int MAX_ENTRIES = wft_pkg::DEF_MAX_ENTRIES,
   parameter int WORD_CHARS  = wft_pkg::DEF_WORD_CHARS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wft_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wft_pkg::rsp_type rsp_data
);

   localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int UW  = EW + 1;
   localparam int LW  = $clog2(WORD_CHARS + 1);
   localparam int WBW = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
   localparam int AW  = $clog2(MAX_ENTRIES * WORD_CHARS);
   localparam int CW  = (UW > 7) ? UW : 7;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_SRCH   = 13'b0000000000010,
      S_LENCHK = 13'b0000000000100,
      S_CMP    = 13'b0000000001000,
      S_CMPCHK = 13'b0000000010000,
      S_UPD    = 13'b0000000100000,
      S_INS    = 13'b0000001000000,
      S_INSW   = 13'b0000010000000,
      S_RDLEN  = 13'b0000100000000,
      S_RDCAP  = 13'b0001000000000,
      S_RDCH   = 13'b0010000000000,
      S_RDPUT  = 13'b0100000000000,
      S_RDWAIT = 13'b1000000000000
   } state_type;

   state_type        st_ff, st_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [UW-1:0]    ent_ff, ent_in;
   logic [LW-1:0]    blen_ff, blen_in;
   logic             ovf_ff, ovf_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [AW-1:0]    insbase_ff, insbase_in;
   logic [LW-1:0]    pos_ff, pos_in;
   logic [LW-1:0]    rlen_ff, rlen_in;
   logic [31:0]      add_ff, add_in;
   wft_pkg::rsp_type rsp_ff, rsp_in;
   logic             rspv_ff, rspv_in;

   logic             wb_we;
   logic [WBW-1:0]   wb_waddr, wb_raddr;
   logic [7:0]       wb_wdata, wb_rdata;
   logic             ch_we;
   logic [AW-1:0]    ch_waddr, ch_raddr;
   logic [7:0]       ch_wdata, ch_rdata;
   logic             len_we;
   logic [EW-1:0]    len_waddr, len_raddr;
   logic [LW-1:0]    len_wdata, len_rdata;
   logic             cnt_we;
   logic [EW-1:0]    cnt_waddr, cnt_raddr;
   logic [31:0]      cnt_wdata, cnt_rdata;

   logic             req_fire;
   logic             rd_empty;
   logic [32:0]      sum;
   logic [EW-1:0]    ridx;

   assign req_ready = (st_ff == S_IDLE) && !rspv_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;
   assign ridx      = EW'(req_data.read_index);
   assign rd_empty  = (CW'(req_data.read_index) >= CW'(used_ff)) ||
                      (CW'(req_data.read_index) >= CW'(MAX_ENTRIES));
   assign sum       = {1'b0, cnt_rdata} + {1'b0, add_ff};

   wft_ram #(.WIDTH(8), .DEPTH(WORD_CHARS)) u_wbuf (
      .clock(clock), .we(wb_we), .waddr(wb_waddr), .wdata(wb_wdata),
      .raddr(wb_raddr), .rdata(wb_rdata));

   wft_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES * WORD_CHARS)) u_chars (
      .clock(clock), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
      .raddr(ch_raddr), .rdata(ch_rdata));

   wft_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_lens (
      .clock(clock), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
      .raddr(len_raddr), .rdata(len_rdata));

   wft_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_cnts (
      .clock(clock), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
      .raddr(cnt_raddr), .rdata(cnt_rdata));

   always_comb begin
      st_in      = st_ff;
      used_in    = used_ff;
      ent_in     = ent_ff;
      blen_in    = blen_ff;
      ovf_in     = ovf_ff;
      base_in    = base_ff;
      insbase_in = insbase_ff;
      pos_in     = pos_ff;
      rlen_in    = rlen_ff;
      add_in     = add_ff;
      rsp_in     = rsp_ff;
      rspv_in    = rspv_ff;
      wb_we      = 1'b0;
      wb_waddr   = blen_ff[WBW-1:0];
      wb_wdata   = req_data.ch;
      wb_raddr   = pos_ff[WBW-1:0];
      ch_we      = 1'b0;
      ch_waddr   = insbase_ff + AW'(pos_ff);
      ch_wdata   = wb_rdata;
      ch_raddr   = base_ff + AW'(pos_ff);
      len_we     = 1'b0;
      len_waddr  = used_ff[EW-1:0];
      len_wdata  = blen_ff;
      len_raddr  = ent_ff[EW-1:0];
      cnt_we     = 1'b0;
      cnt_waddr  = ent_ff[EW-1:0];
      cnt_wdata  = add_ff;
      cnt_raddr  = ent_ff[EW-1:0];

      if (rspv_ff && rsp_ready) begin
         rspv_in = 1'b0;
      end

      case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.func == wft_pkg::FUNC_READ) begin
                  if (rd_empty) begin
                     rsp_in.entry_index = req_data.read_index;
                     rsp_in.out_char    = 8'd0;
                     rsp_in.word_count  = 32'd0;
                     rsp_in.status      = wft_pkg::ST_EMPTY;
                     rsp_in.truncated   = 1'b0;
                     rsp_in.last        = 1'b1;
                     rspv_in            = 1'b1;
                  end else begin
                     ent_in  = UW'(ridx);
                     base_in = AW'(AW'(ridx) * AW'(WORD_CHARS));
                     st_in   = S_RDLEN;
                  end
               end else begin
                  if (blen_ff < LW'(WORD_CHARS)) begin
                     wb_we   = 1'b1;
                     blen_in = blen_ff + LW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_data.word_end) begin
                     add_in  = req_data.add_count;
                     ent_in  = '0;
                     base_in = '0;
                     st_in   = S_SRCH;
                  end
               end
            end
         end
         S_SRCH: begin
            if (ent_ff == used_ff) begin
               if (CW'(used_ff) < CW'(MAX_ENTRIES)) begin
                  pos_in = '0;
                  st_in  = S_INS;
               end else begin
                  rsp_in.entry_index = 6'd0;
                  rsp_in.out_char    = 8'd0;
                  rsp_in.word_count  = 32'd0;
                  rsp_in.status      = wft_pkg::ST_FULL;
                  rsp_in.truncated   = ovf_ff;
                  rsp_in.last        = 1'b1;
                  rspv_in            = 1'b1;
                  blen_in            = '0;
                  ovf_in             = 1'b0;
                  st_in              = S_IDLE;
               end
            end else begin
               st_in = S_LENCHK;
            end
         end
         S_LENCHK: begin
            if (len_rdata == blen_ff) begin
               pos_in = '0;
               st_in  = S_CMP;
            end else begin
               ent_in  = ent_ff + UW'(1);
               base_in = base_ff + AW'(WORD_CHARS);
               st_in   = S_SRCH;
            end
         end
         S_CMP: begin
            if (pos_ff == blen_ff) begin
               st_in = S_UPD;
            end else begin
               st_in = S_CMPCHK;
            end
         end
         S_CMPCHK: begin
            if (ch_rdata == wb_rdata) begin
               pos_in = pos_ff + LW'(1);
               st_in  = S_CMP;
            end else begin
               ent_in  = ent_ff + UW'(1);
               base_in = base_ff + AW'(WORD_CHARS);
               st_in   = S_SRCH;
            end
         end
         S_UPD: begin
            cnt_we             = 1'b1;
            cnt_wdata          = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            rsp_in.entry_index = 6'(ent_ff);
            rsp_in.out_char    = 8'd0;
            rsp_in.word_count  = cnt_wdata;
            rsp_in.status      = wft_pkg::ST_MATCH;
            rsp_in.truncated   = ovf_ff;
            rsp_in.last        = 1'b1;
            rspv_in            = 1'b1;
            blen_in            = '0;
            ovf_in             = 1'b0;
            st_in              = S_IDLE;
         end
         S_INS: begin
            if (pos_ff == blen_ff) begin
               len_we             = 1'b1;
               cnt_we             = 1'b1;
               cnt_waddr          = used_ff[EW-1:0];
               rsp_in.entry_index = 6'(used_ff);
               rsp_in.out_char    = 8'd0;
               rsp_in.word_count  = add_ff;
               rsp_in.status      = wft_pkg::ST_INSERT;
               rsp_in.truncated   = ovf_ff;
               rsp_in.last        = 1'b1;
               rspv_in            = 1'b1;
               used_in            = used_ff + UW'(1);
               insbase_in         = insbase_ff + AW'(WORD_CHARS);
               blen_in            = '0;
               ovf_in             = 1'b0;
               st_in              = S_IDLE;
            end else begin
               st_in = S_INSW;
            end
         end
         S_INSW: begin
            // buffer byte read last cycle lands in the new entry
            ch_we  = 1'b1;
            pos_in = pos_ff + LW'(1);
            st_in  = S_INS;
         end
         S_RDLEN: begin
            st_in = S_RDCAP;
         end
         S_RDCAP: begin
            rlen_in           = len_rdata;
            rsp_in.word_count = cnt_rdata;
            pos_in            = '0;
            st_in             = S_RDCH;
         end
         S_RDCH: begin
            st_in = S_RDPUT;
         end
         S_RDPUT: begin
            rsp_in.entry_index = 6'(ent_ff);
            rsp_in.out_char    = ch_rdata;
            rsp_in.status      = wft_pkg::ST_READOUT;
            rsp_in.truncated   = 1'b0;
            rsp_in.last        = ((pos_ff + LW'(1)) == rlen_ff);
            rspv_in            = 1'b1;
            pos_in             = pos_ff + LW'(1);
            st_in              = S_RDWAIT;
         end
         S_RDWAIT: begin
            if (rspv_ff && rsp_ready) begin
               st_in = rsp_ff.last ? S_IDLE : S_RDCH;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_IDLE;
         used_ff    <= '0;
         blen_ff    <= '0;
         ovf_ff     <= 1'b0;
         insbase_ff <= '0;
         rspv_ff    <= 1'b0;
      end else begin
         st_ff      <= st_in;
         used_ff    <= used_in;
         blen_ff    <= blen_in;
         ovf_ff     <= ovf_in;
         insbase_ff <= insbase_in;
         rspv_ff    <= rspv_in;
      end
      ent_ff  <= ent_in;
      base_ff <= base_in;
      pos_ff  <= pos_in;
      rlen_ff <= rlen_in;
      add_ff  <= add_in;
      rsp_ff  <= rsp_in;
   end

endmodule

>>> rtl/wft_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

>>> rtl/wft_checker.sv
// Port-level checks for the word frequency table, bound to the top level.
`timescale 1ns / 1ps

module wft_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input wft_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input wft_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item dropped or changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req taken while an item waits on rsp");

   a_char_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.func == wft_pkg::FUNC_ADD && !req_data.word_end
      |=> !rsp_valid)
      else $error("result after a mid-word character");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == wft_pkg::ST_FULL
      |-> rsp_data.entry_index == 6'd0 && rsp_data.word_count == 32'd0 && rsp_data.last)
      else $error("table full result carries data");

endmodule

bind word_frequency_table_unit wft_checker u_wft_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
